@@ rtl/dq_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared constants, request codes, payload structs, controller states and the
// command bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

   // Ring store geometry.
   localparam int CAPACITY = 64;
   localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   // Request codes carried in the req_type field.
   localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
   localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
   localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
   localparam logic [1:0] REQ_POP_BACK   = 2'd3;

   // One request item.
   typedef struct packed {
      logic [1:0]               req_type;
      logic signed [DATA_W-1:0] push_value;
   } req_type_type;

   // One result item.
   typedef struct packed {
      logic signed [DATA_W-1:0] pop_value;
      logic                     pop_on_empty;
      logic                     push_dropped;
      logic                     now_empty;
      logic [CNT_W-1:0]         fill_count;
   } rsp_type_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

@@ rtl/dq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences one request at a time: capture, execute, then hold the result
// until the receiver takes it.
// ----------------------------------------------------------------------------
module dq_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output dq_pkg::cmd_type cmd
);

   dq_pkg::state_type state_ff;
   dq_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dq_pkg::ST_IDLE: begin
            if (req_valid) state_in = dq_pkg::ST_EXEC;
         end
         dq_pkg::ST_EXEC: begin
            state_in = dq_pkg::ST_RESP;
         end
         dq_pkg::ST_RESP: begin
            if (rsp_ready) state_in = dq_pkg::ST_IDLE;
         end
         default: begin
            state_in = dq_pkg::ST_IDLE;
         end
      endcase
   end

   // Output logic.
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         dq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         dq_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         dq_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ rtl/dq_datapath.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Holds the ring store, the front and back pointers, the element count, the
// captured request and the result flags.
// ----------------------------------------------------------------------------
module dq_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  dq_pkg::cmd_type      cmd,
   input  dq_pkg::req_type_type req_data,
   output dq_pkg::rsp_type_type rsp_data
);

   localparam logic [dq_pkg::PTR_W-1:0] PTR_LAST = dq_pkg::PTR_W'(dq_pkg::CAPACITY - 1);
   localparam logic [dq_pkg::CNT_W-1:0] CNT_FULL = dq_pkg::CNT_W'(dq_pkg::CAPACITY);

   logic [dq_pkg::DATA_W-1:0] mem [dq_pkg::CAPACITY];

   dq_pkg::req_type_type      req_ff;
   logic [dq_pkg::PTR_W-1:0]  front_ff, front_in;
   logic [dq_pkg::PTR_W-1:0]  back_ff, back_in;
   logic [dq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [dq_pkg::DATA_W-1:0] rd_data_ff;
   logic                      pop_ok_ff, pop_ok_in;
   logic                      empty_pop_ff, empty_pop_in;
   logic                      dropped_ff, dropped_in;

   logic                      wr_en, rd_en;
   logic [dq_pkg::PTR_W-1:0]  wr_addr, rd_addr;
   logic [dq_pkg::PTR_W-1:0]  front_prev, front_next, back_prev, back_next;
   logic                      store_empty, is_full;

   // Ring pointer neighbors, wrapping at the store depth.
   always_comb begin
      front_prev  = (front_ff == '0) ? PTR_LAST : front_ff - 1'b1;
      front_next  = (front_ff == PTR_LAST) ? '0 : front_ff + 1'b1;
      back_prev   = (back_ff == '0) ? PTR_LAST : back_ff - 1'b1;
      back_next   = (back_ff == PTR_LAST) ? '0 : back_ff + 1'b1;
      store_empty = (count_ff == '0);
      is_full     = (count_ff == CNT_FULL);
   end

   // Request decode: pointer moves, store access and result flags.
   always_comb begin
      front_in     = front_ff;
      back_in      = back_ff;
      count_in     = count_ff;
      pop_ok_in    = 1'b0;
      empty_pop_in = 1'b0;
      dropped_in   = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      wr_addr      = back_ff;
      rd_addr      = front_ff;
      unique case (req_ff.req_type)
         dq_pkg::REQ_PUSH_FRONT: begin
            if (is_full) begin
               dropped_in = 1'b1;
            end else begin
               front_in = front_prev;
               wr_addr  = front_prev;
               wr_en    = cmd.exec;
               count_in = count_ff + 1'b1;
            end
         end
         dq_pkg::REQ_PUSH_BACK: begin
            if (is_full) begin
               dropped_in = 1'b1;
            end else begin
               back_in  = back_next;
               wr_addr  = back_ff;
               wr_en    = cmd.exec;
               count_in = count_ff + 1'b1;
            end
         end
         dq_pkg::REQ_POP_FRONT: begin
            if (store_empty) begin
               empty_pop_in = 1'b1;
            end else begin
               front_in  = front_next;
               rd_addr   = front_ff;
               rd_en     = cmd.exec;
               pop_ok_in = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         dq_pkg::REQ_POP_BACK: begin
            if (store_empty) begin
               empty_pop_in = 1'b1;
            end else begin
               back_in   = back_prev;
               rd_addr   = back_prev;
               rd_en     = cmd.exec;
               pop_ok_in = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         default: begin
            dropped_in = 1'b0;
         end
      endcase
   end

   // Pointer and count registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   // Captured request and result flags.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.exec) begin
         pop_ok_ff    <= pop_ok_in;
         empty_pop_ff <= empty_pop_in;
         dropped_ff   <= dropped_in;
      end
   end

   // Ring store with one write port and a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_ff.push_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Result item.
   always_comb begin
      rsp_data.pop_value    = pop_ok_ff ? rd_data_ff : '0;
      rsp_data.pop_on_empty = empty_pop_ff;
      rsp_data.push_dropped = dropped_ff;
      rsp_data.now_empty    = store_empty;
      rsp_data.fill_count   = count_ff;
   end

endmodule

@@ rtl/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of 32-bit signed values kept in a 64-entry ring store.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel takes one request per transfer: push at the front or
//   back, or pop from the front or back. The rsp_ channel returns exactly
//   one result per request with the popped value, the empty-pop and
//   dropped-push flags, and the fill level after the request.
//   A request is handled in steps: capture, store access with the pointer
//   update, and result presentation. After the request transfer, the
//   controller passes its execute state and enters its result state, where
//   the result appears; the next request is taken in the cycle after the
//   result transfer. The ring store has a registered read port.
//   Reset empties the deque: both pointers and the count return to zero.
//   Store contents are not cleared; only written entries are ever read.
//   While the receiver stalls, the result is held steady and no new
//   request is accepted.
// ----------------------------------------------------------------------------
module double_ended_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dq_pkg::req_type_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dq_pkg::rsp_type_type rsp_data
);

   dq_pkg::cmd_type cmd;

   // Request sequencer.
   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Store, pointers and result.
   dq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

`ifndef SYNTH
   // A request transfer is answered by a valid result after the execute state.
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ##1 rsp_valid)
      else $error("result not presented two cycles after request");

   // The block never takes a request while a result is pending.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while result pending");

   // The fill level never exceeds the store depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.fill_count <= dq_pkg::CNT_W'(dq_pkg::CAPACITY)))
      else $error("fill count above capacity");

   // A failed pop reports an empty deque and returns zero.
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.pop_on_empty) |->
         (rsp_data.now_empty && (rsp_data.pop_value == '0) && !rsp_data.push_dropped))
      else $error("empty pop result inconsistent");
`endif

endmodule

@@ test/deque_result_checker.sv @@
// ----------------------------------------------------------------------------
// Deque result checker
// Watches the request and result channels of the double-ended queue. It keeps
// its own copy of the ring store, both pointers and the element count, works
// out the expected result of every accepted request, and compares each
// accepted result field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module deque_result_checker
   import dq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_type_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_type_type rsp_data,
   output int unsigned  fail_count,
   output int unsigned  pending_results
);

   // Mismatch lines beyond this count are only counted.
   localparam int unsigned PRINT_CAP  = 100;
   // Room for expected results that wait for their transfer.
   localparam int unsigned PEND_DEPTH = 16;

   // Shadow deque state.
   logic signed [DATA_W-1:0] shadow_store [CAPACITY];
   int unsigned              head_index;
   int unsigned              tail_index;
   int unsigned              held;

   // Expected results, oldest at the read count.
   rsp_type_type expected_results [PEND_DEPTH];
   int unsigned  exp_wr_count = 0;
   int unsigned  exp_rd_count = 0;
   int unsigned  mismatches   = 0;
   int unsigned  result_index = 0;

   // One line per problem up to the print cap; every problem is counted.
   task automatic report_error(string msg);
      if (mismatches < PRINT_CAP) begin
         $display("checker: result %0d: %s", result_index, msg);
      end
      mismatches++;
   endtask

   // Applies one request to the shadow deque and returns the result it gives.
   function automatic rsp_type_type apply_request(req_type_type r);
      rsp_type_type res;
      res = '0;
      case (r.req_type)
         REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            if (held >= CAPACITY) begin
               res.push_dropped = 1'b1;
            end else if (r.req_type == REQ_PUSH_FRONT) begin
               head_index = (head_index + CAPACITY - 1) % CAPACITY;
               shadow_store[head_index] = r.push_value;
               held++;
            end else begin
               shadow_store[tail_index] = r.push_value;
               tail_index = (tail_index + 1) % CAPACITY;
               held++;
            end
         end
         default: begin
            if (held == 0) begin
               res.pop_on_empty = 1'b1;
            end else if (r.req_type == REQ_POP_FRONT) begin
               res.pop_value = shadow_store[head_index];
               head_index = (head_index + 1) % CAPACITY;
               held--;
            end else begin
               tail_index = (tail_index + CAPACITY - 1) % CAPACITY;
               res.pop_value = shadow_store[tail_index];
               held--;
            end
         end
      endcase
      res.now_empty  = (held == 0);
      res.fill_count = CNT_W'(held);
      return res;
   endfunction

   // Compares one result transfer with the oldest expected result.
   task automatic check_result(rsp_type_type got);
      rsp_type_type want;
      if (exp_wr_count == exp_rd_count) begin
         report_error($sformatf("result transfer with no request waiting (pop_value %0d)",
                                got.pop_value));
      end else begin
         want = expected_results[exp_rd_count % PEND_DEPTH];
         exp_rd_count++;
         if (got.pop_value !== want.pop_value)
            report_error($sformatf("pop_value got %0d, expected %0d",
                                   got.pop_value, want.pop_value));
         if (got.pop_on_empty !== want.pop_on_empty)
            report_error($sformatf("pop_on_empty got %b, expected %b",
                                   got.pop_on_empty, want.pop_on_empty));
         if (got.push_dropped !== want.push_dropped)
            report_error($sformatf("push_dropped got %b, expected %b",
                                   got.push_dropped, want.push_dropped));
         if (got.now_empty !== want.now_empty)
            report_error($sformatf("now_empty got %b, expected %b",
                                   got.now_empty, want.now_empty));
         if (got.fill_count !== want.fill_count)
            report_error($sformatf("fill_count got %0d, expected %0d",
                                   got.fill_count, want.fill_count));
      end
      result_index++;
   endtask

   // Predicts one request and files its result behind the waiting ones.
   task automatic predict_request(req_type_type r);
      rsp_type_type res;
      res = apply_request(r);
      if (exp_wr_count - exp_rd_count >= PEND_DEPTH) begin
         report_error("too many requests without a result transfer");
      end else begin
         expected_results[exp_wr_count % PEND_DEPTH] = res;
         exp_wr_count++;
      end
   endtask

   // Sample both channels at the clock edge. A result always belongs to an
   // earlier request, so it is checked before the new request is predicted.
   always @(posedge clock) begin
      if (reset) begin
         exp_wr_count = 0;
         exp_rd_count = 0;
         head_index   = 0;
         tail_index   = 0;
         held         = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            check_result(rsp_data);
         end
         if (req_valid === 1'b1 && req_ready === 1'b1) begin
            predict_request(req_data);
         end
      end
      fail_count      <= mismatches;
      pending_results <= exp_wr_count - exp_rd_count;
   end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives requests into the deque in random bursts while the receiver stalls
// on its own pattern, including long hold-offs that back up the request
// side. A short directed run covers empty pops, extreme values and both ends;
// random runs then fill the store past full and drain it past empty with
// random values. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
   import dq_pkg::*;

   // Cycles without any transfer before the run is declared hung.
   localparam int unsigned IDLE_LIMIT    = 2000;
   localparam int unsigned LONG_HOLD     = 250;
   localparam int unsigned RANDOM_ITEMS  = 1200;
   localparam int unsigned SETTLE_CYCLES = 10;

   typedef enum int {
      FULL_SPEED,
      RANDOM_STALL,
      SPARSE_READY
   } stall_mode_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_type_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_type_type rsp_data;

   int unsigned fail_count;
   int unsigned pending_results;
   int unsigned burst_left;
   int unsigned random_sent;

   double_ended_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   deque_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic req_type_type make_req(logic [1:0] kind,
                                             logic signed [DATA_W-1:0] value);
      req_type_type r;
      r.req_type   = kind;
      r.push_value = value;
      return r;
   endfunction

   // Uniform values half the time, with the edges of the range and small values mixed in.
   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return 32'sh0000_0000;
         3:       return 32'shFFFF_FFFF;
         4:       return DATA_W'($signed($urandom_range(15)) - 8);
         default: return $urandom;
      endcase
   endfunction

   // Holds the request until its transfer, then closes the burst with a
   // random gap when the burst is used up.
   task automatic send_request(req_type_type r);
      int unsigned gap;
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
   endtask

   // A run of random requests in which push_pct percent are pushes.
   task automatic run_episode(int unsigned n_items, int unsigned push_pct);
      logic [1:0] kind;
      for (int unsigned i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < push_pct)
            kind = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
         else
            kind = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
         send_request(make_req(kind, random_value()));
         random_sent++;
      end
   endtask

   // Stimulus and verdict.
   initial begin : stimulus
      int unsigned bias [5];
      bias = '{95, 75, 50, 25, 5};
      burst_left  = $urandom_range(1, 16);
      random_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty pops, extreme values at both ends, cross-end pops.
      send_request(make_req(REQ_POP_FRONT,  32'sh1234_5678));
      send_request(make_req(REQ_POP_BACK,   32'shFFFF_FFFF));
      send_request(make_req(REQ_PUSH_FRONT, 32'sh7FFF_FFFF));
      send_request(make_req(REQ_PUSH_BACK,  32'sh8000_0000));
      send_request(make_req(REQ_PUSH_FRONT, 32'sh0000_0000));
      send_request(make_req(REQ_PUSH_BACK,  32'shFFFF_FFFF));
      send_request(make_req(REQ_POP_FRONT,  32'sh5555_5555));
      send_request(make_req(REQ_POP_BACK,   32'shAAAA_AAAA));
      send_request(make_req(REQ_POP_FRONT,  32'sh0000_0000));
      send_request(make_req(REQ_POP_BACK,   32'sh7FFF_FFFF));
      send_request(make_req(REQ_POP_BACK,   32'sh8000_0000));
      send_request(make_req(REQ_PUSH_BACK,  32'sh5555_5555));
      send_request(make_req(REQ_PUSH_FRONT, 32'shAAAA_AAAA));
      send_request(make_req(REQ_POP_BACK,   32'sh0F0F_0F0F));
      send_request(make_req(REQ_POP_BACK,   32'shF0F0_F0F0));
      send_request(make_req(REQ_PUSH_FRONT, 32'sh0000_0001));
      send_request(make_req(REQ_POP_FRONT,  32'shFFFF_FFFE));
      send_request(make_req(REQ_POP_FRONT,  32'sh0000_0000));

      // Fill past full to force dropped pushes, then drain past empty.
      run_episode(CAPACITY + 6, 100);
      run_episode(CAPACITY + 6, 0);

      // Random runs with a changing push bias, so the fill level wanders
      // across the whole range and the pointers wrap many times.
      while (random_sent < RANDOM_ITEMS)
         run_episode($urandom_range(20, 150), bias[$urandom_range(4)]);
      req_valid <= 1'b0;

      // The checker's pending count is registered, so it lags the last transfer.
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Receiver: segments of full speed, random stalls and sparse ready, with
   // a long hold-off early on and now and then later.
   initial begin : receiver
      int unsigned    segment;
      int unsigned    span;
      stall_mode_type mode;
      while (reset !== 1'b0) @(posedge clock);
      segment = 0;
      forever begin
         segment++;
         if (segment == 3 || $urandom_range(29) == 0) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            mode = stall_mode_type'($urandom_range(2));
            span = $urandom_range(10, 60);
            for (int unsigned k = 0; k < span; k++) begin
               case (mode)
                  FULL_SPEED:   rsp_ready <= 1'b1;
                  RANDOM_STALL: rsp_ready <= ($urandom_range(2) != 0);
                  default:      rsp_ready <= (k % 4 == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ files.f @@
rtl/dq_pkg.sv
rtl/dq_ctrl.sv
rtl/dq_datapath.sv
rtl/double_ended_queue.sv
test/deque_result_checker.sv
test/tb_top.sv
